[design/min_max_median_mean_stats_assert.svh]
// Assertion macros for the set statistics block.
// Used by the port checker; needs nothing else.
`ifndef MIN_MAX_MEDIAN_MEAN_STATS_ASSERT_SVH
`define MIN_MAX_MEDIAN_MEAN_STATS_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MMS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mms assertion failed");

// Next-cycle implication, disabled in reset.
`define MMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mms assertion failed");

`endif

[design/mms_pkg.sv]
// Shared constants, types and states of the set statistics block.
// Stands alone; every other file but the assertion header refers to it by scoped names.
`default_nettype none

package mms_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;
   localparam int COUNT_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_ITEMS);
   localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
   localparam int DVD_BITS    = SUM_BITS + FRAC_BITS;
   localparam int STEP_BITS   = $clog2(DVD_BITS + 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic        [COUNT_BITS-1:0]  count_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic signed [MEAN_BITS-1:0]   mean_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic     done;
      mean_type mean;
   } div_result_type;

endpackage

`default_nettype wire

[design/mms_if.sv]
// Handshake channels of the set statistics block: sample beats in, result beats out.
// Depends on mms_pkg for payload types.
`default_nettype none

interface mms_req_if;
   logic                valid;
   logic                ready;
   mms_pkg::sample_type sample;
   logic                last_item;

   modport source (output valid, output sample, output last_item, input ready);
   modport sink (input valid, input sample, input last_item, output ready);
endinterface

interface mms_rsp_if;
   logic                valid;
   logic                ready;
   mms_pkg::sample_type min_value;
   mms_pkg::sample_type max_value;
   mms_pkg::sample_type median_value;
   mms_pkg::mean_type   mean_fixed;
   mms_pkg::count_type  item_count;
   logic                overflow;

   modport source (output valid, output min_value, output max_value, output median_value,
                   output mean_fixed, output item_count, output overflow, input ready);
   modport sink (input valid, input min_value, input max_value, input median_value,
                 input mean_fixed, input item_count, input overflow, output ready);
endinterface

`default_nettype wire

[design/mms_cell.sv]
// One cell of the sorting row: holds one sample and its valid bit.
// Depends on mms_pkg for the sample and control types.
`default_nettype none

module mms_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  mms_pkg::cell_ctrl_type ctrl,
   input  mms_pkg::sample_type    sample,
   input  mms_pkg::sample_type    left_value,
   input  wire                    left_le,
   input  wire                    left_valid,
   input  mms_pkg::sample_type    right_value,
   input  wire                    right_valid,
   output mms_pkg::sample_type    value,
   output logic                   valid,
   output logic                   le
);

   mms_pkg::sample_type value_ff, value_in;
   logic                valid_ff, valid_in;

   // Stored value sorts at or before the incoming sample.
   assign le = valid_ff && (value_ff <= sample);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      priority if (ctrl.insert) begin
         // keep, take the new sample, or take the left neighbor's value
         if (!le) begin
            value_in = left_le ? sample : left_value;
         end
         valid_in = valid_ff | left_valid;
      end else if (ctrl.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

[design/mms_divider.sv]
// Restoring divider for the mean: (sum * 2^FRAC_BITS) / count, truncated toward zero.
// Depends on mms_pkg for widths and the result struct.
`default_nettype none

module mms_divider (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  mms_pkg::sum_type        sum,
   input  mms_pkg::count_type      count,
   output mms_pkg::div_result_type result
);

   logic [mms_pkg::DVD_BITS-1:0]   dvd_ff, dvd_in;
   mms_pkg::count_type             rem_ff, rem_in;
   mms_pkg::count_type             div_ff, div_in;
   logic                           neg_ff, neg_in;
   logic [mms_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [mms_pkg::COUNT_BITS:0]   rem_sh;
   logic [mms_pkg::COUNT_BITS:0]   rem_new;
   logic                           fits;
   logic [mms_pkg::SUM_BITS-1:0]   mag;
   logic [mms_pkg::DVD_BITS-1:0]   quot;

   always_comb begin
      mag     = sum[mms_pkg::SUM_BITS-1] ? (-sum) : sum;
      rem_sh  = {rem_ff, dvd_ff[mms_pkg::DVD_BITS-1]};
      fits    = rem_sh >= {1'b0, div_ff};
      rem_new = fits ? (rem_sh - {1'b0, div_ff}) : rem_sh;

      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      priority if (start) begin
         dvd_in  = {mag, mms_pkg::FRAC_BITS'(0)};
         rem_in  = '0;
         div_in  = count;
         neg_in  = sum[mms_pkg::SUM_BITS-1];
         step_in = mms_pkg::STEP_BITS'(mms_pkg::DVD_BITS);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // one quotient bit a cycle, shifted in at the bottom
         dvd_in  = {dvd_ff[mms_pkg::DVD_BITS-2:0], fits};
         rem_in  = rem_new[mms_pkg::COUNT_BITS-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == mms_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         // idle: hold the quotient and the done flag
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot        = neg_ff ? (-dvd_ff) : dvd_ff;
   assign result.done = done_ff;
   assign result.mean = quot[mms_pkg::MEAN_BITS-1:0];

endmodule

`default_nettype wire

[design/min_max_median_mean_stats.sv]
// Top level of the set statistics block: a sorting row of cells, a divider and the sequencer.
// Depends on mms_pkg, mms_if, mms_cell and mms_divider.
//
// Samples of a set arrive as req beats, one per clock while ready is high, the final one marked by last_item.
// Each kept sample drops into a row of MAX_ITEMS cells that stays sorted ascending; an
// equal sample lands after those already stored. A running sum and count advance with
// every kept sample. Samples that arrive with the row full are dropped and raise the
// overflow bit of the result. After the last beat, req_if.ready goes low while the row
// drains out through cell 0 (picking off min, median at index n/2 and max for n kept
// samples) and a restoring divider forms the mean over DVD_BITS (30) quotient bits,
// one quotient bit per step. The result register is loaded once both the drain and
// the divider have finished and the register is free; rsp_if.valid then rises. The
// drain also empties the row, so the next set starts from scratch. The finished result
// sits in an output register; once it is loaded, sample beats of the next set are
// taken again even while the rsp side stalls.
`default_nettype none

module min_max_median_mean_stats (
   input  wire               clock,
   input  wire               reset,
   mms_req_if.sink           req_if,
   mms_rsp_if.source         rsp_if
);

   localparam int N = mms_pkg::MAX_ITEMS;

   mms_pkg::state_type      state_ff, state_in;
   mms_pkg::sum_type        sum_ff, sum_in;
   mms_pkg::count_type      count_ff, count_in;
   logic                    drop_ff, drop_in;
   mms_pkg::count_type      n_ff;
   logic                    ovf_ff;
   mms_pkg::count_type      k_ff;
   logic                    drained_ff;
   mms_pkg::sample_type     min_cap_ff, med_cap_ff, max_cap_ff;

   logic                    rsp_valid_ff;
   mms_pkg::sample_type     rsp_min_ff, rsp_max_ff, rsp_med_ff;
   mms_pkg::mean_type       rsp_mean_ff;
   mms_pkg::count_type      rsp_count_ff;
   logic                    rsp_ovf_ff;

   logic                    accept;
   logic                    has_room;
   logic                    finished;
   logic                    out_free;
   logic                    out_load;
   logic                    req_ready;
   logic                    div_start;
   mms_pkg::cell_ctrl_type  ctrl;
   mms_pkg::div_result_type div_res;

   mms_pkg::sample_type     cell_value [N];
   logic                    cell_valid [N];
   logic                    cell_le    [N];

   assign accept   = req_if.valid && req_ready;
   assign has_room = count_ff < mms_pkg::COUNT_BITS'(N);
   assign finished = drained_ff && div_res.done;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Running totals as they stand after this beat.
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      if (accept) begin
         if (has_room) begin
            sum_in   = sum_ff + mms_pkg::SUM_BITS'(req_if.sample);
            count_in = count_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mms_pkg::ST_LOAD: begin
            if (accept && req_if.last_item) begin
               state_in = mms_pkg::ST_DRAIN;
            end
         end
         mms_pkg::ST_DRAIN: begin
            if (finished) begin
               state_in = out_free ? mms_pkg::ST_LOAD : mms_pkg::ST_WAIT;
            end
         end
         mms_pkg::ST_WAIT: begin
            if (out_free) begin
               state_in = mms_pkg::ST_LOAD;
            end
         end
         default: state_in = mms_pkg::ST_LOAD;
      endcase
   end

   // Outputs of the sequencer. Ready is high throughout the load state, so valid
   // alone marks a beat there.
   always_comb begin
      req_ready   = 1'b0;
      div_start   = 1'b0;
      ctrl.insert = 1'b0;
      ctrl.shift  = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         mms_pkg::ST_LOAD: begin
            req_ready   = 1'b1;
            ctrl.insert = req_if.valid && has_room;
            div_start   = req_if.valid && req_if.last_item;
         end
         mms_pkg::ST_DRAIN: begin
            ctrl.shift = !drained_ff;
            out_load   = finished && out_free;
         end
         mms_pkg::ST_WAIT: begin
            out_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_if.ready = req_ready;

   // Sorting row: cell 0 sees a virtual neighbor that always sorts first.
   for (genvar i = 0; i < N; i++) begin : g_cell
      mms_pkg::sample_type lv, rv;
      logic                lle, lvd, rvd;
      if (i == 0) begin : g_first
         assign lv  = req_if.sample;
         assign lle = 1'b1;
         assign lvd = 1'b1;
      end else begin : g_inner
         assign lv  = cell_value[i-1];
         assign lle = cell_le[i-1];
         assign lvd = cell_valid[i-1];
      end
      if (i == N - 1) begin : g_last
         assign rv  = '0;
         assign rvd = 1'b0;
      end else begin : g_body
         assign rv  = cell_value[i+1];
         assign rvd = cell_valid[i+1];
      end
      mms_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .sample      (req_if.sample),
         .left_value  (lv),
         .left_le     (lle),
         .left_valid  (lvd),
         .right_value (rv),
         .right_valid (rvd),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .le          (cell_le[i])
      );
   end

   mms_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sum    (sum_in),
      .count  (count_in),
      .result (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mms_pkg::ST_LOAD;
         sum_ff       <= '0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         drained_ff   <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Clear the totals at the end of a set; keep its count and flag for the drain.
         if (div_start) begin
            sum_ff     <= '0;
            count_ff   <= '0;
            drop_ff    <= 1'b0;
            drained_ff <= 1'b0;
            k_ff       <= '0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
            drop_ff  <= drop_in;
            if (ctrl.shift) begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == n_ff - 1'b1) begin
                  drained_ff <= 1'b1;
               end
            end
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture and result payload registers.
   always_ff @(posedge clock) begin
      if (div_start) begin
         n_ff   <= count_in;
         ovf_ff <= drop_in;
      end
      if (ctrl.shift) begin
         // cell 0 shows sorted element k before this shift
         if (k_ff == '0) begin
            min_cap_ff <= cell_value[0];
         end
         if (k_ff == (n_ff >> 1)) begin
            med_cap_ff <= cell_value[0];
         end
         if (k_ff == n_ff - 1'b1) begin
            max_cap_ff <= cell_value[0];
         end
      end
      if (out_load) begin
         rsp_min_ff   <= min_cap_ff;
         rsp_max_ff   <= max_cap_ff;
         rsp_med_ff   <= med_cap_ff;
         rsp_mean_ff  <= div_res.mean;
         rsp_count_ff <= n_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.min_value    = rsp_min_ff;
   assign rsp_if.max_value    = rsp_max_ff;
   assign rsp_if.median_value = rsp_med_ff;
   assign rsp_if.mean_fixed   = rsp_mean_ff;
   assign rsp_if.item_count   = rsp_count_ff;
   assign rsp_if.overflow     = rsp_ovf_ff;

endmodule

`default_nettype wire

[design/mms_checker.sv]
// Port checker for the set statistics block, bound to the top level.
// Depends on mms_pkg and the assertion macro header.
`default_nettype none

`include "min_max_median_mean_stats_assert.svh"

module mms_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_ready,
   input wire                 req_last_item,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input mms_pkg::sample_type min_value,
   input mms_pkg::sample_type max_value,
   input mms_pkg::sample_type median_value,
   input mms_pkg::count_type  item_count,
   input wire                 overflow
);

   // A stalled result beat holds.
   `MMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(median_value) && $stable(item_count))

   // Median sits between min and max.
   `MMS_ASSERT_IMPLY(a_order, clock, reset, rsp_valid, (min_value <= median_value) && (median_value <= max_value))

   // A result covers at least one sample, and a dropped sample means the row was full.
   `MMS_ASSERT_IMPLY(a_count, clock, reset, rsp_valid, (item_count != '0) && (!overflow || (item_count == mms_pkg::COUNT_BITS'(mms_pkg::MAX_ITEMS))))

   // Intake stops after the last beat of a set.
   `MMS_ASSERT_NEXT(a_stop, clock, reset, req_valid && req_ready && req_last_item, !req_ready)

endmodule

bind min_max_median_mean_stats mms_checker u_mms_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_last_item (req_if.last_item),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .min_value     (rsp_if.min_value),
   .max_value     (rsp_if.max_value),
   .median_value  (rsp_if.median_value),
   .item_count    (rsp_if.item_count),
   .overflow      (rsp_if.overflow)
);

`default_nettype wire
